// File: sv/lqfl_pkg.sv
// ----------------------------------------------------------------------------
// lqfl_pkg
// Shared types, constants and helpers for the linked queue with free list.
// ----------------------------------------------------------------------------
package lqfl_pkg;

  // Node pool size and pointer geometry; the pointer value NODES means null.
  localparam int unsigned NODES  = 16;
  localparam int unsigned ADDR_W = $clog2(NODES);
  localparam int unsigned PTR_W  = $clog2(NODES + 1);
  localparam int unsigned DATA_W = 32;

  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NODES);

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    op_e                      operation;
    logic signed [DATA_W-1:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    status_e                  status;
  } out_word_t;

  // Any pointer at or beyond NODES counts as null.
  function automatic logic is_node(input logic [PTR_W-1:0] ptr);
    is_node = (ptr < NULL_PTR);
  endfunction

  // Link value of an entry never written since reset: next entry, last is null.
  function automatic logic [PTR_W-1:0] link_reset(input logic [ADDR_W-1:0] addr);
    if (addr == ADDR_W'(NODES - 1)) begin
      link_reset = NULL_PTR;
    end else begin
      link_reset = PTR_W'(addr) + PTR_W'(1);
    end
  endfunction

endpackage

// File: sv/lqfl_ram.sv
// ----------------------------------------------------------------------------
// lqfl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lqfl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/linked_queue_free_list_unit.sv
// ----------------------------------------------------------------------------
// linked_queue_free_list_unit
// FIFO queue kept as a singly linked list in a fixed node pool, with unused
// nodes threaded on a free list through the same link memory.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+--------------------------------
//   in      | input     | in_valid_i/in_ready_o | in_word_i  (operation, push_value)
//   out     | output    | out_valid_o/out_ready_i | out_word_o (pop_value, status)
//
// Steps: the accept cycle issues the link and value memory reads; then, in
//   S_EXEC, the unit updates the pointers, writes the memories back and
//   loads the result register. A new word is taken only back in S_IDLE.
// Reset: pointers clear at once; link entries read as their reset chain via
//   per-entry written flags, so there is no clearing pass.
// Stalls: a waiting result does not block the next accept; the update cycle
//   holds only while the result register is still full.
// ----------------------------------------------------------------------------
module linked_queue_free_list_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lqfl_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lqfl_pkg::out_word_t out_word_o
);

  // Control state
  lqfl_pkg::state_e                 state_q, state_d;
  logic [lqfl_pkg::PTR_W-1:0]       front_q, front_d;
  logic [lqfl_pkg::PTR_W-1:0]       rear_q, rear_d;
  logic [lqfl_pkg::PTR_W-1:0]       free_q, free_d;
  logic                             out_valid_q, out_valid_d;
  logic [lqfl_pkg::NODES-1:0]       lnk_vld_q, lnk_vld_d;
  logic                             lnk_rvld_q;

  // Payload registers
  lqfl_pkg::op_e                    op_q;
  logic signed [lqfl_pkg::DATA_W-1:0] val_q;
  lqfl_pkg::out_word_t              out_q, out_d;
  logic [lqfl_pkg::ADDR_W-1:0]      lnk_raddr_q;

  // Memory ports
  logic                             lnk_re, lnk_we;
  logic [lqfl_pkg::ADDR_W-1:0]      lnk_raddr, lnk_waddr;
  logic [lqfl_pkg::PTR_W-1:0]       lnk_rdata, lnk_wdata, lnk_eff;
  logic                             val_re, val_we;
  logic [lqfl_pkg::ADDR_W-1:0]      val_raddr, val_waddr;
  logic [lqfl_pkg::DATA_W-1:0]      val_rdata, val_wdata;

  logic                             in_acc;
  logic                             finish;

  assign in_ready_o = (state_q == lqfl_pkg::S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Issue reads on accept: pop follows the front, push follows the free head.
  assign lnk_re    = in_acc;
  assign lnk_raddr = (in_word_i.operation == lqfl_pkg::OP_POP)
                     ? front_q[lqfl_pkg::ADDR_W-1:0] : free_q[lqfl_pkg::ADDR_W-1:0];
  assign val_re    = in_acc && (in_word_i.operation == lqfl_pkg::OP_POP);
  assign val_raddr = front_q[lqfl_pkg::ADDR_W-1:0];

  // Unwritten link entries answer with their reset chain value.
  assign lnk_eff = lnk_rvld_q ? lnk_rdata : lqfl_pkg::link_reset(lnk_raddr_q);

  lqfl_ram #(
    .WIDTH(lqfl_pkg::PTR_W),
    .DEPTH(lqfl_pkg::NODES)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (lnk_we),
    .waddr_i(lnk_waddr),
    .wdata_i(lnk_wdata),
    .re_i   (lnk_re),
    .raddr_i(lnk_raddr),
    .rdata_o(lnk_rdata)
  );

  lqfl_ram #(
    .WIDTH(lqfl_pkg::DATA_W),
    .DEPTH(lqfl_pkg::NODES)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_waddr),
    .wdata_i(val_wdata),
    .re_i   (val_re),
    .raddr_i(val_raddr),
    .rdata_o(val_rdata)
  );

  // Next state, pointer update and memory write-back
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    rear_d      = rear_q;
    free_d      = free_q;
    lnk_vld_d   = lnk_vld_q;
    out_d       = out_q;
    finish      = 1'b0;
    lnk_we      = 1'b0;
    lnk_waddr   = rear_q[lqfl_pkg::ADDR_W-1:0];
    lnk_wdata   = free_q;
    val_we      = 1'b0;
    val_waddr   = free_q[lqfl_pkg::ADDR_W-1:0];
    val_wdata   = val_q;

    unique case (state_q)
      lqfl_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = lqfl_pkg::S_EXEC;
        end
      end
      lqfl_pkg::S_EXEC: begin
        // hold until the result register has room
        if (!out_valid_q || out_ready_i) begin
          finish           = 1'b1;
          state_d          = lqfl_pkg::S_IDLE;
          out_d.pop_value  = '0;
          out_d.status     = lqfl_pkg::ST_OK;
          unique case (op_q)
            lqfl_pkg::OP_PUSH: begin
              if (!lqfl_pkg::is_node(free_q)) begin
                out_d.status = lqfl_pkg::ST_OVERFLOW;
              end else begin
                // take the free head, store the value, link it after the rear
                free_d = lnk_eff;
                val_we = 1'b1;
                if (lqfl_pkg::is_node(rear_q)) begin
                  lnk_we    = 1'b1;
                  lnk_waddr = rear_q[lqfl_pkg::ADDR_W-1:0];
                  lnk_wdata = free_q;
                end else begin
                  front_d = free_q;
                end
                rear_d = free_q;
              end
            end
            lqfl_pkg::OP_POP: begin
              if (!lqfl_pkg::is_node(front_q)) begin
                out_d.status = lqfl_pkg::ST_UNDERFLOW;
              end else begin
                // unlink the front and return it to the free list head
                out_d.pop_value = val_rdata;
                lnk_we          = 1'b1;
                lnk_waddr       = front_q[lqfl_pkg::ADDR_W-1:0];
                lnk_wdata       = free_q;
                free_d          = front_q;
                // the rear carries the end of the list, so front == rear
                // means this pop drains the queue
                if (front_q == rear_q) begin
                  front_d = lqfl_pkg::NULL_PTR;
                  rear_d  = lqfl_pkg::NULL_PTR;
                end else begin
                  front_d = lnk_eff;
                end
              end
            end
            default: begin
              out_d.status = lqfl_pkg::ST_OK;
            end
          endcase
        end
      end
      default: begin
        state_d = lqfl_pkg::S_IDLE;
      end
    endcase

    if (lnk_we) begin
      lnk_vld_d[lnk_waddr] = 1'b1;
    end
  end

  // Result register: load on finish, drop on take
  always_comb begin
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lqfl_pkg::S_IDLE;
      front_q     <= lqfl_pkg::NULL_PTR;
      rear_q      <= lqfl_pkg::NULL_PTR;
      free_q      <= '0;
      out_valid_q <= 1'b0;
      lnk_vld_q   <= '0;
      lnk_rvld_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
      lnk_vld_q   <= lnk_vld_d;
      if (lnk_re) begin
        lnk_rvld_q <= lnk_vld_q[lnk_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q        <= in_word_i.operation;
      val_q       <= in_word_i.push_value;
      lnk_raddr_q <= lnk_raddr;
    end
    if (finish) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Assertions
  a_ptr_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lqfl_pkg::is_node(front_q) == lqfl_pkg::is_node(rear_q))
    else $error("front and rear disagree on empty queue");

  a_free_not_rear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lqfl_pkg::is_node(free_q) && lqfl_pkg::is_node(rear_q)) |-> (free_q != rear_q))
    else $error("free head aliases the rear node");

  a_result_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == lqfl_pkg::S_EXEC))
    else $error("result appeared without an update cycle");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.status == lqfl_pkg::ST_OVERFLOW ||
                     out_word_o.status == lqfl_pkg::ST_UNDERFLOW))
    |-> (out_word_o.pop_value == '0))
    else $error("failed operation returned nonzero data");

endmodule
